// ===== hdl/set_assoc_lru_writeback_cache_core_defines.svh =====
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_core_defines
// Assertion macros shared by the cache core RTL.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define SALC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cache core assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cache core assertion failed");

`endif

// ===== hdl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, types and codes of the set-associative cache core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

   localparam int MAX_WAYS  = 8;
   localparam int MAX_SETS  = 256;
   localparam int ADDR_BITS = 32;

   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W    = WAY_W;
   localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int TAG_W     = ADDR_BITS;

   localparam int OFFSET_W    = 3;
   localparam int INDEX_W     = 4;
   localparam int WAYS_CFG_W  = 4;
   localparam int SHAMT_W     = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int OUTCOME_W   = 2;
   localparam int WAY_FIELD_W = 3;

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_USED   = 2'd2
   } csr_index_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_READ_HIT   = 2'd0,
      OUT_WRITE_HIT  = 2'd1,
      OUT_READ_MISS  = 2'd2,
      OUT_WRITE_MISS = 2'd3
   } outcome_type;

   typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0]             dirty;
      logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
   } set_state_type;

   localparam int TAG_ROW_W = $bits(tag_row_type);
   localparam int STATE_W   = $bits(set_state_type);

   typedef struct packed {
      logic                  is_read;
      logic [TAG_W-1:0]      tag;
      logic [WAYS_CFG_W-1:0] ways_used;
      logic                  row_ok;
      tag_row_type           tag_row;
      set_state_type         state_row;
   } lookup_in_type;

   typedef struct packed {
      outcome_type       outcome;
      logic              did_writeback;
      logic [WAY_W-1:0]  way;
      tag_row_type       tag_row;
      set_state_type     state_row;
   } lookup_out_type;

endpackage

`default_nettype wire

// ===== hdl/salc_intf.sv =====
// ----------------------------------------------------------------------------
// salc_intf
// Request and response channel interfaces of the cache core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface salc_req_if import salc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [ADDR_BITS-1:0] address;

   modport source (output valid, req_type, address, input ready);
   modport sink   (input valid, req_type, address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OUTCOME_W-1:0]   outcome;
   logic                   did_writeback;
   logic [WAY_FIELD_W-1:0] way_used;

   modport source (output valid, outcome, did_writeback, way_used, input ready);
   modport sink   (input valid, outcome, did_writeback, way_used, output ready);
endinterface

`default_nettype wire

// ===== hdl/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/salc_lookup.sv =====
// ----------------------------------------------------------------------------
// salc_lookup
// Tag compare, victim choice and set row update for one access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salc_lookup import salc_pkg::*; (
   input  wire lookup_in_type  lk_in,
   output      lookup_out_type lk_out
);

   set_state_type          st;
   set_state_type          nst;
   tag_row_type            ntag;
   logic [WAY_CNT_W-1:0]   n_ways;
   logic [MAX_WAYS-1:0]    active;
   logic [MAX_WAYS-1:0]    hit_vec;
   logic [MAX_WAYS-1:0]    free_vec;
   logic                   hit;
   logic                   free_any;
   logic [WAY_W-1:0]       hit_way;
   logic [WAY_W-1:0]       free_way;
   logic [WAY_W-1:0]       best;
   logic [WAY_W-1:0]       way;
   logic [WAY_CNT_W-1:0]   old_rank;
   logic                   wb;
   logic                   is_write;

   always_comb begin
      // a row never written since reset reads as all invalid
      st       = lk_in.row_ok ? lk_in.state_row : '0;
      is_write = (lk_in.is_read == REQ_WRITE);

      if (lk_in.ways_used == '0) begin
         n_ways = WAY_CNT_W'(1);
      end else if (int'(lk_in.ways_used) > MAX_WAYS) begin
         n_ways = WAY_CNT_W'(MAX_WAYS);
      end else begin
         n_ways = WAY_CNT_W'(lk_in.ways_used);
      end

      for (int v = 0; v < MAX_WAYS; v++) begin
         active[v]   = (WAY_CNT_W'(v) < n_ways);
         hit_vec[v]  = active[v] & st.valid[v] & (lk_in.tag_row[v] == lk_in.tag);
         free_vec[v] = active[v] & ~st.valid[v];
      end

      // lowest matching / lowest free way
      hit      = 1'b0;
      hit_way  = '0;
      free_any = 1'b0;
      free_way = '0;
      for (int v = MAX_WAYS - 1; v >= 0; v--) begin
         if (hit_vec[v]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(v);
         end
         if (free_vec[v]) begin
            free_any = 1'b1;
            free_way = WAY_W'(v);
         end
      end

      // oldest active way, lowest index on ties
      best = '0;
      for (int v = 1; v < MAX_WAYS; v++) begin
         if (active[v] && (st.rank[v] > st.rank[best])) begin
            best = WAY_W'(v);
         end
      end

      wb = 1'b0;
      priority if (hit) begin
         way      = hit_way;
         old_rank = WAY_CNT_W'(st.rank[hit_way]);
      end else if (free_any) begin
         way      = free_way;
         old_rank = WAY_CNT_W'(MAX_WAYS);
      end else begin
         way      = best;
         old_rank = WAY_CNT_W'(st.rank[best]);
         wb       = st.dirty[best];
      end

      // age the ways that were younger than the touched one
      nst = st;
      for (int v = 0; v < MAX_WAYS; v++) begin
         if (WAY_W'(v) == way) begin
            nst.rank[v] = '0;
         end else if (active[v] && st.valid[v] && (WAY_CNT_W'(st.rank[v]) < old_rank)
                      && (st.rank[v] < RANK_MAX)) begin
            nst.rank[v] = st.rank[v] + RANK_W'(1);
         end
      end
      nst.valid[way] = 1'b1;
      nst.dirty[way] = hit ? (st.dirty[way] | is_write) : is_write;

      ntag = lk_in.tag_row;
      if (!hit) begin
         ntag[way] = lk_in.tag;
      end

      priority if (hit && is_write) begin
         lk_out.outcome = OUT_WRITE_HIT;
      end else if (hit) begin
         lk_out.outcome = OUT_READ_HIT;
      end else if (is_write) begin
         lk_out.outcome = OUT_WRITE_MISS;
      end else begin
         lk_out.outcome = OUT_READ_MISS;
      end
      lk_out.did_writeback = wb;
      lk_out.way           = way;
      lk_out.tag_row       = ntag;
      lk_out.state_row     = nst;
   end

endmodule

`default_nettype wire

// ===== hdl/set_assoc_lru_writeback_cache_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_core
// Tag and line-state engine of a set-associative write-back, write-allocate
// cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Each transaction has a read step and an update step: the first reads the
// set row from the tag memory and the state memory (valid, dirty and LRU
// rank per way), the second compares all ways, picks the hit, the lowest
// free way or the LRU victim, writes the updated row back and loads the
// response register. The set row is read through the registered memory read,
// then modified and written back. A new request is taken while a response
// still waits; the update step stalls only while the response register is
// full. Set rows written since reset are tracked by one flag per set, so
// there is no clearing pass after reset. Configuration (offset bits, index
// bits, ways in use) may be written only while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_lru_writeback_cache_core_defines.svh"

module set_assoc_lru_writeback_cache_core import salc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   salc_req_if.sink                    req_chan,
   salc_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type              state_ff,        state_in;
   logic [OFFSET_W-1:0]    offset_bits_ff,  offset_bits_in;
   logic [INDEX_W-1:0]     index_bits_ff,   index_bits_in;
   logic [WAYS_CFG_W-1:0]  ways_used_ff,    ways_used_in;
   logic [MAX_SETS-1:0]    row_valid_ff,    row_valid_in;
   logic                   row_ok_ff,       row_ok_in;
   logic                   is_read_ff,      is_read_in;
   logic [TAG_W-1:0]       tag_ff,          tag_in;
   logic [SET_W-1:0]       set_ff,          set_in;
   logic                   rsp_valid_ff,    rsp_valid_in;
   logic [OUTCOME_W-1:0]   rsp_outcome_ff,  rsp_outcome_in;
   logic                   rsp_wb_ff,       rsp_wb_in;
   logic [WAY_FIELD_W-1:0] rsp_way_ff,      rsp_way_in;

   logic                   accept;
   logic                   update_go;
   logic [SHAMT_W-1:0]     shamt;
   logic [ADDR_BITS-1:0]   addr_shifted;
   logic [15:0]            index_mask;
   logic [15:0]            set_wide;
   logic [SET_W-1:0]       req_set;
   logic [TAG_W-1:0]       req_tag;
   logic [TAG_ROW_W-1:0]   tag_rd;
   logic [STATE_W-1:0]     state_rd;
   lookup_in_type          lk_in;
   lookup_out_type         lk_out;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;
   // update waits only for room in the response register
   assign update_go      = (state_ff == ST_UPDATE) & (~rsp_valid_ff | rsp_chan.ready);

   // address split: set = index bits above the offset, tag = everything above
   assign shamt        = SHAMT_W'(offset_bits_ff) + SHAMT_W'(index_bits_ff);
   assign addr_shifted = req_chan.address >> offset_bits_ff;
   assign index_mask   = (16'h1 << index_bits_ff) - 16'h1;
   assign set_wide     = addr_shifted[15:0] & index_mask;
   assign req_set      = set_wide[SET_W-1:0];  // wraps at the set count
   assign req_tag      = req_chan.address >> shamt;

   salc_ram #(
      .WIDTH (TAG_ROW_W),
      .DEPTH (MAX_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (update_go),
      .wr_addr (set_ff),
      .wr_data (lk_out.tag_row),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (tag_rd)
   );

   salc_ram #(
      .WIDTH (STATE_W),
      .DEPTH (MAX_SETS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (update_go),
      .wr_addr (set_ff),
      .wr_data (lk_out.state_row),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (state_rd)
   );

   assign lk_in.is_read   = is_read_ff;
   assign lk_in.tag       = tag_ff;
   assign lk_in.ways_used = ways_used_ff;
   assign lk_in.row_ok    = row_ok_ff;
   assign lk_in.tag_row   = tag_row_type'(tag_rd);
   assign lk_in.state_row = set_state_type'(state_rd);

   salc_lookup u_lookup (
      .lk_in  (lk_in),
      .lk_out (lk_out)
   );

   always_comb begin
      state_in       = state_ff;
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      ways_used_in   = ways_used_ff;
      row_valid_in   = row_valid_ff;
      row_ok_in      = row_ok_ff;
      is_read_in     = is_read_ff;
      tag_in         = tag_ff;
      set_in         = set_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_wb_in      = rsp_wb_ff;
      rsp_way_in     = rsp_way_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_bits_in = csr_wdata[OFFSET_W-1:0];
            CSR_INDEX_BITS:  index_bits_in  = csr_wdata[INDEX_W-1:0];
            CSR_WAYS_USED:   ways_used_in   = csr_wdata[WAYS_CFG_W-1:0];
            default: ;
         endcase
      end

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_UPDATE;
               is_read_in = req_chan.req_type;
               tag_in     = req_tag;
               set_in     = req_set;
               // row flag sampled alongside the registered memory read
               row_ok_in  = row_valid_ff[req_set];
            end
         end
         ST_UPDATE: begin
            if (update_go) begin
               state_in              = ST_IDLE;
               row_valid_in[set_ff]  = 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_outcome_in        = lk_out.outcome;
               rsp_wb_in             = lk_out.did_writeback;
               rsp_way_in            = WAY_FIELD_W'(lk_out.way);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         offset_bits_ff <= OFFSET_W'(3);
         index_bits_ff  <= INDEX_W'(4);
         ways_used_ff   <= WAYS_CFG_W'(8);
         row_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         ways_used_ff   <= ways_used_in;
         row_valid_ff   <= row_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ok_ff      <= row_ok_in;
      is_read_ff     <= is_read_in;
      tag_ff         <= tag_in;
      set_ff         <= set_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_wb_ff      <= rsp_wb_in;
      rsp_way_ff     <= rsp_way_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.outcome       = rsp_outcome_ff;
   assign rsp_chan.did_writeback = rsp_wb_ff;
   assign rsp_chan.way_used      = rsp_way_ff;

   // every accepted request moves on to the update cycle
   `SALC_ASSERT_NEXT(a_accept_to_update, accept, state_ff == ST_UPDATE)
   // set rows are written back only in the update cycle
   `SALC_ASSERT_NOW(a_write_in_update, update_go, state_ff == ST_UPDATE)
   // a row write always leaves a response behind
   `SALC_ASSERT_NEXT(a_write_gives_rsp, update_go, rsp_valid_ff && row_valid_ff[set_ff])
   // hits never report a write-back
   `SALC_ASSERT_NOW(a_hit_no_wb,
      rsp_valid_ff && (rsp_outcome_ff == OUT_READ_HIT || rsp_outcome_ff == OUT_WRITE_HIT),
      !rsp_wb_ff)

endmodule

`default_nettype wire
